[rtl/core/hct_pkg.sv]
// Shared constants, types and helper functions of the heightmap cell triangulator.
package hct_pkg;

    localparam int CHUNK_SIZE_DEF = 64;
    localparam int MAX_CELLS      = 64;
    localparam int LINE_DEPTH     = MAX_CELLS + 1;
    localparam int CQ_DEPTH_DEF   = 4;
    localparam int OQ_DEPTH_DEF   = 4;

    localparam int POS_W  = 7;
    localparam int SMP_W  = 8;
    localparam int HMAX_W = 12;
    localparam int Y_W    = 20;
    localparam int UV_W   = 17;
    localparam int K_W    = 3;

    localparam int UV_ONE = 65536;
    localparam int UV_EPS = 66;

    // Rounded division by 255 through a reciprocal: exact for all dividends below 2^21.
    localparam int          DIV_IN_W  = Y_W + 1;
    localparam int          RECIP_W   = 22;
    localparam int          PROD_W    = DIV_IN_W + RECIP_W;
    localparam int          RECIP_SH  = 29;
    localparam int          Q_W       = 13;
    localparam logic [RECIP_W-1:0]  RECIP_M   = 22'd2105377;
    localparam logic [DIV_IN_W-1:0] ROUND_OFS = 21'd127;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HMAX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HMAX = 2'd2;

    localparam logic [POS_W-1:0]  CELLS_RESET = 7'd64;
    localparam logic [POS_W-1:0]  CELLS_MAX   = 7'd64;
    localparam logic [POS_W-1:0]  CELLS_MIN   = 7'd1;
    localparam logic [HMAX_W-1:0] HMAX_RESET  = 12'd255;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    localparam logic [K_W-1:0] K_LAST = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]            cx;
        logic [POS_W-1:0]            cz;
        logic [3:0][SMP_W-1:0]       smp;
    } t_cell;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [Y_W-1:0]   pos_y;
        logic [POS_W-1:0] pos_z;
        logic [UV_W-1:0]  tex_u;
        logic [UV_W-1:0]  tex_v;
        logic [1:0]       corner;
        logic             last;
    } t_vtx;

    // Corner visited at each vertex step: two triangles 1,0,2 and 2,3,1.
    function automatic logic [1:0] corner_of(input logic [K_W-1:0] k);
        logic [1:0] c;
        unique case (k)
            3'd0:    c = CORNER_TR;
            3'd1:    c = CORNER_TL;
            3'd2:    c = CORNER_BL;
            3'd3:    c = CORNER_BL;
            3'd4:    c = CORNER_BR;
            default: c = CORNER_TR;
        endcase
        return c;
    endfunction

    function automatic logic [POS_W-1:0] clamp_cells(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v < CELLS_MIN) begin
            r = CELLS_MIN;
        end else if (v > CELLS_MAX) begin
            r = CELLS_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/core/hct_ram.sv]
// Generic single-write, single-read RAM with registered read-first output.
module hct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/core/hct_fifo.sv]
// Small register-based first-in first-out queue with occupancy count.
module hct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_rdata = r_data[r_rp];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wp] <= i_wdata;
        end
    end

endmodule

[rtl/core/hct_front.sv]
// Front end: sample counters, line store and assembly of the four corner samples of a cell.
module hct_front import hct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [SMP_W-1:0] i_height_sample,
    input  logic             i_first,
    input  logic [POS_W-1:0] i_cols,
    input  logic [POS_W-1:0] i_rows,
    input  logic             i_cq_full,
    output logic             o_cq_push,
    output t_cell            o_cell
);

    logic                  w_acc;
    logic [POS_W-1:0]      w_col;
    logic [POS_W-1:0]      w_row;
    logic [POS_W-1:0]      w_cols;
    logic [POS_W-1:0]      w_rows;
    logic [POS_W-1:0]      r_col;
    logic [POS_W-1:0]      r_row;
    logic [POS_W-1:0]      n_col;
    logic [POS_W-1:0]      n_row;
    logic [LINE_DEPTH-1:0] r_vld;

    logic                  r_b_vld;
    logic [SMP_W-1:0]      r_b_s;
    logic [POS_W-1:0]      r_b_col;
    logic [POS_W-1:0]      r_b_row;
    logic                  r_b_upv;
    logic [SMP_W-1:0]      r_left;
    logic [SMP_W-1:0]      r_upl;
    logic [SMP_W-1:0]      w_rdata;
    logic [SMP_W-1:0]      w_upper;
    logic                  w_cell;
    logic                  w_b_go;

    assign w_acc  = i_push & ~o_full;
    assign w_col  = i_first ? '0 : r_col;
    assign w_row  = i_first ? '0 : r_row;
    assign w_cols = clamp_cells(i_cols);
    assign w_rows = clamp_cells(i_rows);

    always_comb begin
        if (w_col >= w_cols) begin
            n_col = '0;
            n_row = (w_row >= w_rows) ? '0 : w_row + 1'b1;
        end else begin
            n_col = w_col + 1'b1;
            n_row = w_row;
        end
    end

    // The line store is read and overwritten at the same column on the same edge.
    hct_ram #(
        .WIDTH (SMP_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (w_col),
        .i_wdata (i_height_sample),
        .i_re    (w_acc),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    assign w_upper   = r_b_upv ? w_rdata : '0;
    assign w_cell    = (r_b_col != '0) && (r_b_row != '0);
    assign w_b_go    = ~r_b_vld | ~w_cell | ~i_cq_full;
    assign o_full    = ~w_b_go;
    assign o_cq_push = r_b_vld & w_cell & ~i_cq_full;

    always_comb begin
        o_cell                = '0;
        o_cell.cx             = r_b_col - 1'b1;
        o_cell.cz             = r_b_row - 1'b1;
        o_cell.smp[CORNER_TL] = r_upl;
        o_cell.smp[CORNER_TR] = w_upper;
        o_cell.smp[CORNER_BL] = r_left;
        o_cell.smp[CORNER_BR] = r_b_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_vld   <= '0;
            r_b_vld <= 1'b0;
            r_left  <= '0;
            r_upl   <= '0;
        end else begin
            if (w_acc) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_vld[w_col] <= 1'b1;
            end
            if (w_b_go) begin
                r_b_vld <= w_acc;
            end
            if (r_b_vld && w_b_go) begin
                r_left <= r_b_s;
                r_upl  <= w_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b_s   <= i_height_sample;
            r_b_col <= w_col;
            r_b_row <= w_row;
            r_b_upv <= r_vld[w_col];
        end
    end

endmodule

[rtl/core/hct_back.sv]
// Back end: walks each cell through its six vertices and computes height and texture per vertex.
module hct_back import hct_pkg::*; #(
    parameter int CHUNK_SIZE = CHUNK_SIZE_DEF,
    parameter int OQ_DEPTH   = OQ_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cq_empty,
    input  t_cell                         i_cell,
    output logic                          o_cq_pop,
    input  logic [HMAX_W-1:0]             i_hmax,
    input  logic [$clog2(OQ_DEPTH+1)-1:0] i_oq_count,
    output logic                          o_oq_push,
    output t_vtx                          o_oq_vtx
);

    localparam int CW = $clog2(OQ_DEPTH + 1) + 1;

    logic [UV_W-1:0] w_tex_near [LINE_DEPTH];
    logic [UV_W-1:0] w_tex_far  [LINE_DEPTH];

    // Texture coordinate per grid line, pulled inward by epsilon and saturated.
    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_tex
        localparam int unsigned TB = (g * UV_ONE + CHUNK_SIZE / 2) / CHUNK_SIZE;
        localparam int unsigned TN = (TB + UV_EPS > UV_ONE) ? UV_ONE : TB + UV_EPS;
        localparam int unsigned TF = (TB < UV_EPS) ? 0 :
                                     ((TB - UV_EPS > UV_ONE) ? UV_ONE : TB - UV_EPS);
        assign w_tex_near[g] = UV_W'(TN);
        assign w_tex_far[g]  = UV_W'(TF);
    end

    logic [K_W-1:0]      r_k;
    logic [CW-1:0]       w_inflight;
    logic                w_issue;
    logic [1:0]          w_c;
    logic [POS_W-1:0]    w_px;
    logic [POS_W-1:0]    w_pz;
    logic [SMP_W-1:0]    w_smp;
    t_vtx                w_vtx;

    logic                r_s1_vld;
    t_vtx                r_s1_vtx;
    logic [DIV_IN_W-1:0] w_y;
    logic [PROD_W-1:0]   w_prod;
    logic                r_s2_vld;
    t_vtx                r_s2_vtx;
    logic [Q_W-1:0]      r_s2_q;

    // Only issue a vertex when the result queue is sure to have room for it.
    assign w_inflight = CW'(i_oq_count) + CW'(r_s1_vld) + CW'(r_s2_vld);
    assign w_issue    = ~i_cq_empty && (w_inflight < CW'(OQ_DEPTH));
    assign o_cq_pop   = w_issue && (r_k == K_LAST);

    assign w_c   = corner_of(r_k);
    assign w_px  = i_cell.cx + POS_W'(w_c[0]);
    assign w_pz  = i_cell.cz + POS_W'(w_c[1]);
    assign w_smp = i_cell.smp[w_c];

    always_comb begin
        w_vtx        = '0;
        w_vtx.pos_x  = w_px;
        w_vtx.pos_z  = w_pz;
        w_vtx.pos_y  = Y_W'(w_smp) * Y_W'(i_hmax);
        w_vtx.tex_u  = w_c[0] ? w_tex_far[w_px] : w_tex_near[w_px];
        w_vtx.tex_v  = w_c[1] ? w_tex_far[w_pz] : w_tex_near[w_pz];
        w_vtx.corner = w_c;
        w_vtx.last   = (r_k == K_LAST);
    end

    // Height = p + floor((p + 127) / 255), where p = sample * height_max.
    assign w_y    = DIV_IN_W'(r_s1_vtx.pos_y) + ROUND_OFS;
    assign w_prod = PROD_W'(w_y) * PROD_W'(RECIP_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_issue) begin
                r_k <= (r_k == K_LAST) ? '0 : r_k + 1'b1;
            end
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_vtx <= w_vtx;
        r_s2_vtx <= r_s1_vtx;
        r_s2_q   <= w_prod[RECIP_SH +: Q_W];
    end

    assign o_oq_push = r_s2_vld;

    always_comb begin
        o_oq_vtx       = r_s2_vtx;
        o_oq_vtx.pos_y = r_s2_vtx.pos_y + Y_W'(r_s2_q);
    end

endmodule

[rtl/core/heightmap_cell_triangulator_top.sv]
// Top level of the heightmap cell triangulator: configuration registers and the two queues.
//
// Usage. Heightmap samples of one chunk enter in raster order on a queue-like
// input: a word is taken at a clock edge where push is high and full is low.
// Setting i_first on a word restarts the column and row counters at the
// chunk's top-left corner. Every sample that closes a grid cell yields six
// vertex words (two triangles, corners 1,0,2,2,3,1); edge samples yield none.
// Vertex words leave through a queue-like output: the oldest word sits on the
// o_ ports while empty is low and is taken at an edge where pop is high.
// Configuration (cells across, cells down, maximum height) is written through
// its own valid/ready channel, which is always ready; write it only while the
// block is idle.
// The front end takes a sample every cycle while full is low; the back end
// issues one vertex per cycle, while the result queue has room, through a
// two-stage multiply pipeline, so a run of cell-closing samples is paced by
// the six vertices that each of them yields.
// When pop stays low the result queue fills, vertex issue halts, the queue of
// cells between front and back fills and full rises; nothing is dropped.
// Synchronous reset clears the counters, the line store's valid bits, the
// neighbour samples and both queues, and restores the configuration defaults.
module heightmap_cell_triangulator_top import hct_pkg::*; #(
    parameter int CHUNK_SIZE = CHUNK_SIZE_DEF,
    parameter int CQ_DEPTH   = CQ_DEPTH_DEF,
    parameter int OQ_DEPTH   = OQ_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  push,
    output logic                  full,
    input  logic [SMP_W-1:0]      i_height_sample,
    input  logic                  i_first,

    output logic                  empty,
    input  logic                  pop,
    output logic [POS_W-1:0]      o_pos_x,
    output logic [Y_W-1:0]        o_pos_y,
    output logic [POS_W-1:0]      o_pos_z,
    output logic [UV_W-1:0]       o_tex_u,
    output logic [UV_W-1:0]       o_tex_v,
    output logic [1:0]            o_corner,
    output logic                  o_last,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [POS_W-1:0]  r_cols;
    logic [POS_W-1:0]  r_rows;
    logic [HMAX_W-1:0] r_hmax;

    assign o_cfg_ready = 1'b1;

    // Registers beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CELLS_RESET;
            r_rows <= CELLS_RESET;
            r_hmax <= HMAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COLS: r_cols <= i_cfg_data[POS_W-1:0];
                CFG_ROWS: r_rows <= i_cfg_data[POS_W-1:0];
                CFG_HMAX: r_hmax <= i_cfg_data[HMAX_W-1:0];
                default:  ;
            endcase
        end
    end

    logic                          w_cq_push;
    logic                          w_cq_full;
    logic                          w_cq_empty;
    logic                          w_cq_pop;
    t_cell                         w_cell_in;
    t_cell                         w_cell_out;
    logic [$clog2(CQ_DEPTH+1)-1:0] w_cq_count;

    logic                          w_oq_push;
    t_vtx                          w_vtx_in;
    t_vtx                          w_vtx_out;
    logic                          w_oq_full;
    logic [$clog2(OQ_DEPTH+1)-1:0] w_oq_count;

    hct_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_height_sample (i_height_sample),
        .i_first         (i_first),
        .i_cols          (r_cols),
        .i_rows          (r_rows),
        .i_cq_full       (w_cq_full),
        .o_cq_push       (w_cq_push),
        .o_cell          (w_cell_in)
    );

    hct_fifo #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (CQ_DEPTH)
    ) u_cell_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cq_push),
        .i_wdata (w_cell_in),
        .i_pop   (w_cq_pop),
        .o_rdata (w_cell_out),
        .o_empty (w_cq_empty),
        .o_full  (w_cq_full),
        .o_count (w_cq_count)
    );

    hct_back #(
        .CHUNK_SIZE (CHUNK_SIZE),
        .OQ_DEPTH   (OQ_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cq_empty (w_cq_empty),
        .i_cell     (w_cell_out),
        .o_cq_pop   (w_cq_pop),
        .i_hmax     (r_hmax),
        .i_oq_count (w_oq_count),
        .o_oq_push  (w_oq_push),
        .o_oq_vtx   (w_vtx_in)
    );

    // The back end only issues against free slots, so the result queue never overflows.
    hct_fifo #(
        .WIDTH ($bits(t_vtx)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_wdata (w_vtx_in),
        .i_pop   (pop),
        .o_rdata (w_vtx_out),
        .o_empty (empty),
        .o_full  (w_oq_full),
        .o_count (w_oq_count)
    );

    assign o_pos_x  = w_vtx_out.pos_x;
    assign o_pos_y  = w_vtx_out.pos_y;
    assign o_pos_z  = w_vtx_out.pos_z;
    assign o_tex_u  = w_vtx_out.tex_u;
    assign o_tex_v  = w_vtx_out.tex_v;
    assign o_corner = w_vtx_out.corner;
    assign o_last   = w_vtx_out.last;

endmodule

[rtl/core/hct_chk.sv]
// Port-level checker of the heightmap cell triangulator, bound to the top level.
module hct_chk import hct_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic [SMP_W-1:0]      i_height_sample,
    input logic                  i_first,
    input logic                  empty,
    input logic                  pop,
    input logic [POS_W-1:0]      o_pos_x,
    input logic [Y_W-1:0]        o_pos_y,
    input logic [POS_W-1:0]      o_pos_z,
    input logic [UV_W-1:0]       o_tex_u,
    input logic [UV_W-1:0]       o_tex_v,
    input logic [1:0]            o_corner,
    input logic                  o_last,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Reset leaves the result queue drained and the input open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    // A waiting word holds while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable({o_pos_x, o_pos_y, o_pos_z,
                                                  o_tex_u, o_tex_v, o_corner, o_last})))
        else $error("result word changed while stalled");

    // The closing vertex of a cell is always its top-right corner.
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_corner == CORNER_TR))
        else $error("last vertex is not the top-right corner");

    // A right-hand or lower corner never sits on the chunk's first grid line.
    a_corner_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((!o_corner[0] || o_pos_x != '0) && (!o_corner[1] || o_pos_z != '0)))
        else $error("corner position inconsistent with corner code");

    // A popped closing vertex is followed, on the next word, by a first vertex.
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last) |=> (empty || (!o_last && o_corner == CORNER_TR)))
        else $error("cell does not restart at its first vertex");

endmodule

bind heightmap_cell_triangulator_top hct_chk u_hct_chk (.*);
